// File: rtl/core/regeneration_supervisor_fsm_unit_macros.svh
// Assertion macros used by the regeneration supervisor checker.
`ifndef REGENERATION_SUPERVISOR_FSM_UNIT_MACROS_SVH
`define REGENERATION_SUPERVISOR_FSM_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RSF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/rsf_pkg.sv
// Types and constants of the regeneration supervisor.
`default_nettype none

package rsf_pkg;

   // Register field widths.
   localparam int PRESSURE_BITS   = 16;
   localparam int SALT_BITS       = 11;
   localparam int REGEN_TIME_BITS = 27;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 27;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_PRESSURE   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_SALT       = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_REGEN_TIME = 2'd2;

   // Register reset values: 20 psi, 10 percent, two minutes.
   localparam logic [PRESSURE_BITS-1:0]   MIN_PRESSURE_RESET   = 16'd320;
   localparam logic [SALT_BITS-1:0]       MIN_SALT_RESET       = 11'd160;
   localparam logic [REGEN_TIME_BITS-1:0] MAX_REGEN_TIME_RESET = 27'd120000;

   // Supervisor states.
   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_MONITOR = 2'd1,
      ST_REGEN   = 2'd2,
      ST_FAULT   = 2'd3
   } state_type;

   // Condition events.
   typedef enum logic [2:0] {
      COND_NONE          = 3'd0,
      COND_DATA_LOSS     = 3'd1,
      COND_LOW_PRESSURE  = 3'd2,
      COND_LOW_SALT      = 3'd3,
      COND_REGEN_STARTED = 3'd4
   } cond_type;

   // Exit events out of regen running.
   typedef enum logic [1:0] {
      EXIT_NONE     = 2'd0,
      EXIT_FAILED   = 2'd1,
      EXIT_TIMER    = 2'd2,
      EXIT_EXTERNAL = 2'd3
   } exit_type;

endpackage

`default_nettype wire

// File: rtl/core/regeneration_supervisor_fsm_unit.sv
// Regeneration supervisor: one evaluation tick per transfer, one result per tick.
//
// Usage:
//   The req_ channel carries one evaluation tick: data valid flag, pressure,
//   salt level, regenerating flag, millisecond time and the start and abort
//   requests. The rsp_ channel returns one result per tick: new state,
//   condition event, exit event, stop command count and start command.
//   Both channels transfer at a rising edge with valid high and stall low.
//   A tick is registered in the input stage, evaluated from there, and its
//   result is registered in the result stage, which drives rsp_.
//   Throughput: one tick per cycle while rsp_stall is low. The supervisor
//   state register closes a loop through the compare and time subtract logic.
//   The csr_ port writes thresholds and the cycle length; write it only
//   while no tick is in flight.
//   Reset (synchronous, active high) returns the supervisor to idle, clears
//   the timer state, empties both stages and restores the register defaults.
//   When the receiver stalls, the result is held unchanged and one more
//   tick is still taken into the input stage; req_stall then rises.
`default_nettype none

module regeneration_supervisor_fsm_unit #(
   parameter int TIME_BITS = 32
) (
   input  wire                                       clock,
   input  wire                                       reset,
   // Configuration write port.
   input  wire                                       csr_write,
   input  wire  [rsf_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  wire  [rsf_pkg::CSR_DATA_BITS-1:0]         csr_wdata,
   // Tick input channel.
   input  wire                                       req_valid,
   output logic                                      req_stall,
   input  wire                                       req_data_valid,
   input  wire  [rsf_pkg::PRESSURE_BITS-1:0]         req_pressure,
   input  wire  [rsf_pkg::SALT_BITS-1:0]             req_salt_level,
   input  wire                                       req_regenerating,
   input  wire  [TIME_BITS-1:0]                      req_now_ms,
   input  wire                                       req_start_request,
   input  wire                                       req_abort_request,
   // Result channel.
   output logic                                      rsp_valid,
   input  wire                                       rsp_stall,
   output logic [1:0]                                rsp_new_state,
   output logic [2:0]                                rsp_condition_event,
   output logic [1:0]                                rsp_exit_event,
   output logic [1:0]                                rsp_stop_commands,
   output logic                                      rsp_start_command
);

   // Width for comparing elapsed time against the cycle length.
   localparam int CMP_BITS = (TIME_BITS > rsf_pkg::REGEN_TIME_BITS) ?
                             TIME_BITS : rsf_pkg::REGEN_TIME_BITS;

   // Configuration registers.
   logic [rsf_pkg::PRESSURE_BITS-1:0]   min_pressure_ff;
   logic [rsf_pkg::SALT_BITS-1:0]       min_salt_ff;
   logic [rsf_pkg::REGEN_TIME_BITS-1:0] max_regen_time_ff;

   // Input stage.
   logic                                op_valid_ff;
   logic                                op_data_valid_ff;
   logic [rsf_pkg::PRESSURE_BITS-1:0]   op_pressure_ff;
   logic [rsf_pkg::SALT_BITS-1:0]       op_salt_ff;
   logic                                op_regen_ff;
   logic [TIME_BITS-1:0]                op_now_ff;
   logic                                op_start_ff;
   logic                                op_abort_ff;

   // Supervisor state.
   rsf_pkg::state_type                  state_ff;
   rsf_pkg::state_type                  state_in;
   logic [TIME_BITS-1:0]                start_time_ff;
   logic [TIME_BITS-1:0]                start_time_in;
   logic                                stop_sent_ff;
   logic                                stop_sent_in;

   // Result stage.
   logic                                rsp_valid_ff;
   rsf_pkg::state_type                  rsp_state_ff;
   rsf_pkg::cond_type                   rsp_cond_ff;
   rsf_pkg::exit_type                   rsp_exit_ff;
   logic [1:0]                          rsp_stops_ff;
   logic                                rsp_start_ff;

   // Evaluation results and working values.
   rsf_pkg::cond_type                   cond_in;
   rsf_pkg::exit_type                   exit_in;
   logic [1:0]                          stops_in;
   logic                                start_in;
   logic                                fault;
   logic                                regen_active;
   logic                                regen_entry;
   logic [TIME_BITS-1:0]                base_time;
   logic                                base_sent;
   logic [TIME_BITS-1:0]                elapsed;
   logic                                timer_expired;

   // Handshake control.
   logic                                req_transfer;
   logic                                advance;

   assign advance      = op_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = op_valid_ff && !advance;
   assign req_transfer = req_valid && !req_stall;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_pressure_ff   <= rsf_pkg::MIN_PRESSURE_RESET;
         min_salt_ff       <= rsf_pkg::MIN_SALT_RESET;
         max_regen_time_ff <= rsf_pkg::MAX_REGEN_TIME_RESET;
      end else if (csr_write) begin
         case (csr_index)
            rsf_pkg::CSR_MIN_PRESSURE: begin
               min_pressure_ff <= csr_wdata[rsf_pkg::PRESSURE_BITS-1:0];
            end
            rsf_pkg::CSR_MIN_SALT: begin
               min_salt_ff <= csr_wdata[rsf_pkg::SALT_BITS-1:0];
            end
            rsf_pkg::CSR_MAX_REGEN_TIME: begin
               max_regen_time_ff <= csr_wdata[rsf_pkg::REGEN_TIME_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Input stage valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff <= 1'b0;
      end else if (req_transfer) begin
         op_valid_ff <= 1'b1;
      end else if (advance) begin
         op_valid_ff <= 1'b0;
      end
   end

   // Input stage payload.
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         op_data_valid_ff <= req_data_valid;
         op_pressure_ff   <= req_pressure;
         op_salt_ff       <= req_salt_level;
         op_regen_ff      <= req_regenerating;
         op_now_ff        <= req_now_ms;
         op_start_ff      <= req_start_request;
         op_abort_ff      <= req_abort_request;
      end
   end

   // Regeneration timer: restart on entry, then measure wrapping elapsed time.
   assign regen_active  = op_data_valid_ff && op_regen_ff;
   assign regen_entry   = (state_ff != rsf_pkg::ST_REGEN);
   assign base_time     = regen_entry ? op_now_ff : start_time_ff;
   assign base_sent     = regen_entry ? 1'b0 : stop_sent_ff;
   assign elapsed       = op_now_ff - base_time;
   assign timer_expired = (CMP_BITS'(elapsed) >= CMP_BITS'(max_regen_time_ff));

   // Next state, events and commands by fixed priority.
   always_comb begin
      state_in      = state_ff;
      start_time_in = start_time_ff;
      stop_sent_in  = stop_sent_ff;
      cond_in       = rsf_pkg::COND_NONE;
      exit_in       = rsf_pkg::EXIT_NONE;
      stops_in      = 2'd0;
      start_in      = 1'b0;
      fault         = 1'b0;

      if (!op_data_valid_ff) begin
         if (state_ff != rsf_pkg::ST_IDLE) begin
            cond_in = rsf_pkg::COND_DATA_LOSS;
         end
         state_in = rsf_pkg::ST_IDLE;
         fault    = 1'b1;
      end else if (op_pressure_ff < min_pressure_ff) begin
         if (state_ff != rsf_pkg::ST_FAULT) begin
            cond_in = rsf_pkg::COND_LOW_PRESSURE;
         end
         state_in = rsf_pkg::ST_FAULT;
         fault    = 1'b1;
      end else if (op_salt_ff < min_salt_ff) begin
         if (state_ff != rsf_pkg::ST_FAULT) begin
            cond_in = rsf_pkg::COND_LOW_SALT;
         end
         state_in = rsf_pkg::ST_FAULT;
         fault    = 1'b1;
      end else if (regen_active) begin
         if (regen_entry) begin
            cond_in = rsf_pkg::COND_REGEN_STARTED;
         end
         start_time_in = base_time;
         stop_sent_in  = base_sent;
         // A single stop once the cycle length is reached.
         if (timer_expired && !base_sent) begin
            stops_in     = stops_in + 2'd1;
            stop_sent_in = 1'b1;
         end
         state_in = rsf_pkg::ST_REGEN;
      end else begin
         state_in = rsf_pkg::ST_MONITOR;
      end

      // Leaving regen running reports how the cycle ended.
      if (state_ff == rsf_pkg::ST_REGEN && state_in != rsf_pkg::ST_REGEN) begin
         if (fault) begin
            stops_in = stops_in + 2'd1;
            exit_in  = rsf_pkg::EXIT_FAILED;
         end else if (stop_sent_ff) begin
            exit_in = rsf_pkg::EXIT_TIMER;
         end else begin
            exit_in = rsf_pkg::EXIT_EXTERNAL;
         end
         stop_sent_in  = 1'b0;
         start_time_in = '0;
         // The machine still runs after a pressure or salt fault.
         if (fault && regen_active) begin
            stops_in = stops_in + 2'd1;
         end
      end

      // Abort wins over start; start only when monitoring.
      if (op_abort_ff) begin
         if (state_in == rsf_pkg::ST_REGEN) begin
            stops_in = stops_in + 2'd1;
         end
      end else if (op_start_ff && !fault && state_in != rsf_pkg::ST_REGEN) begin
         start_in = 1'b1;
      end
   end

   // Supervisor state register, updated as each tick is evaluated.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rsf_pkg::ST_IDLE;
         start_time_ff <= '0;
         stop_sent_ff  <= 1'b0;
      end else if (advance) begin
         state_ff      <= state_in;
         start_time_ff <= start_time_in;
         stop_sent_ff  <= stop_sent_in;
      end
   end

   // Result stage valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result stage payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_state_ff <= state_in;
         rsp_cond_ff  <= cond_in;
         rsp_exit_ff  <= exit_in;
         rsp_stops_ff <= stops_in;
         rsp_start_ff <= start_in;
      end
   end

   // Result channel outputs.
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_new_state       = rsp_state_ff;
   assign rsp_condition_event = rsp_cond_ff;
   assign rsp_exit_event      = rsp_exit_ff;
   assign rsp_stop_commands   = rsp_stops_ff;
   assign rsp_start_command   = rsp_start_ff;

endmodule

`default_nettype wire

// File: rtl/core/rsf_checker.sv
// Port-level checker of the regeneration supervisor and its bind.
`default_nettype none

`include "regeneration_supervisor_fsm_unit_macros.svh"

module rsf_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_stall,
   input wire [1:0] rsp_new_state,
   input wire [2:0] rsp_condition_event,
   input wire [1:0] rsp_exit_event,
   input wire [1:0] rsp_stop_commands,
   input wire       rsp_start_command
);

   // A stalled result stays valid with its state, stop count and exit event unchanged.
   `RSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_new_state) && $stable(rsp_stop_commands) && $stable(rsp_exit_event), "stalled result changed")

   // A start command is only issued while monitoring.
   `RSF_ASSERT_SAME(a_start_monitor, clock, reset, rsp_valid && rsp_start_command, rsp_new_state == rsf_pkg::ST_MONITOR, "start issued outside monitoring")

   // Two stops come from a fault with the machine running or timer plus abort.
   `RSF_ASSERT_SAME(a_two_stops, clock, reset, rsp_valid && rsp_stop_commands == 2'd2, rsp_new_state == rsf_pkg::ST_FAULT || rsp_new_state == rsf_pkg::ST_REGEN, "two stops in wrong state")

   // An exit event means regen running was left.
   `RSF_ASSERT_SAME(a_exit_left, clock, reset, rsp_valid && rsp_exit_event != rsf_pkg::EXIT_NONE, rsp_new_state != rsf_pkg::ST_REGEN && rsp_condition_event != rsf_pkg::COND_REGEN_STARTED, "exit event while regenerating")

endmodule

bind regeneration_supervisor_fsm_unit rsf_checker u_rsf_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_new_state       (rsp_new_state),
   .rsp_condition_event (rsp_condition_event),
   .rsp_exit_event      (rsp_exit_event),
   .rsp_stop_commands   (rsp_stop_commands),
   .rsp_start_command   (rsp_start_command)
);

`default_nettype wire
